FILE: hw/rtl/mrpq_pkg.sv
// ----------------------------------------------------------------------------
// mrpq_pkg
// Shared sizes, codes, command/status bundles and pointer helpers for the
// multi-reader packet queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrpq_pkg;

  // Storage sizing.
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_READERS = 8;
  localparam int WORD_BITS   = 32;

  // Pointers run over twice the depth so full and empty differ.
  localparam int PTR_SPAN = 2 * QUEUE_DEPTH;
  localparam int PTR_W    = $clog2(PTR_SPAN);
  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int RD_W     = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CNT_W    = $clog2(MAX_READERS + 1);

  // Port field widths.
  localparam int KIND_W   = 3;
  localparam int SUB_W    = 3;
  localparam int AMT_W    = 7;
  localparam int PKT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 3'd0,
    KIND_REGISTER = 3'd1,
    KIND_COUNT    = 3'd2,
    KIND_READ     = 3'd3,
    KIND_CONSUME  = 3'd4,
    KIND_RECLAIM  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 3'd0,
    STATUS_RANGE   = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_NO_SLOT = 3'd3,
    STATUS_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RECLAIM,
    ST_RD_ADDR,
    ST_RD_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;
    logic commit;
    logic start_read;
    logic step_reclaim;
    logic issue_read;
    logic emit_packet;
  } mrpq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_reclaim;
    logic read_go;
    logic reclaim_done;
    logic read_last;
    logic out_free;
  } mrpq_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(PTR_SPAN - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] from_p,
                                                input logic [PTR_W-1:0] to_p);
    logic [PTR_W:0] t;
    if (to_p >= from_p) t = {1'b0, to_p} - {1'b0, from_p};
    else t = {1'b0, to_p} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, from_p};
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    if (p >= PTR_W'(QUEUE_DEPTH)) t = p - PTR_W'(QUEUE_DEPTH);
    else t = p;
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (PTR_W + 1)'(PTR_SPAN)) s = s - (PTR_W + 1)'(PTR_SPAN);
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrpq_ctrl.sv
// ----------------------------------------------------------------------------
// mrpq_ctrl
// Request sequencer: takes one word at a time, then steers the datapath
// through checking, reclaiming or packet read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mrpq_pkg::mrpq_stat_t stat_i,
  output mrpq_pkg::mrpq_cmd_t  cmd_o
);
  import mrpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.is_reclaim) begin
          state_d = ST_RECLAIM;
        end else if (stat_i.read_go) begin
          cmd_o.start_read = 1'b1;
          state_d          = ST_RD_ADDR;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RECLAIM: begin
        // One packet freed per cycle until a reader or the writer is met.
        if (!stat_i.reclaim_done) begin
          cmd_o.step_reclaim = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        cmd_o.issue_read = 1'b1;
        state_d          = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_packet = 1'b1;
          state_d           = stat_i.read_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mrpq_datapath.sv
// ----------------------------------------------------------------------------
// mrpq_datapath
// Request register, queue pointers, packet store and the output word
// register, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrpq_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mrpq_pkg::mrpq_cmd_t              cmd_i,
  output mrpq_pkg::mrpq_stat_t             stat_o,
  input  logic [mrpq_pkg::KIND_W-1:0]      kind_i,
  input  logic [mrpq_pkg::SUB_W-1:0]       subscriber_i,
  input  logic [mrpq_pkg::AMT_W-1:0]       amount_i,
  input  logic [mrpq_pkg::PKT_W-1:0]       packet_word_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [mrpq_pkg::STATUS_W-1:0]    status_o,
  output logic [mrpq_pkg::VALUE_W-1:0]     value_o,
  output logic [mrpq_pkg::PKT_W-1:0]       packet_out_o,
  output logic                             carries_packet_o,
  output logic                             last_o
);
  import mrpq_pkg::*;

  // Request held for the duration of its work.
  logic [KIND_W-1:0]    req_kind_q;
  logic [SUB_W-1:0]     req_sub_q;
  logic [AMT_W-1:0]     req_amount_q;
  logic [WORD_BITS-1:0] req_word_q;

  // Queue state.
  logic [PTR_W-1:0] oldest_q;
  logic [PTR_W-1:0] write_q;
  logic [PTR_W-1:0] rp_q [MAX_READERS];
  logic [CNT_W-1:0] count_q;

  // Read-out walker.
  logic [PTR_W-1:0] rd_ptr_q;
  logic [AMT_W-1:0] remain_q;

  logic [WORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [WORD_BITS-1:0] mem_rdata_q;

  // Output word register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  value_q;
  logic [PKT_W-1:0]    packet_q;
  logic                carries_q;
  logic                last_q;

  logic [RD_W-1:0]  sub_idx;
  logic             sub_ok;
  logic [PTR_W-1:0] rp_sel;
  logic [PTR_W-1:0] pending;
  logic [PTR_W-1:0] held;
  logic             amt_ok;
  logic             blocked;
  status_e          res_status;
  logic [VALUE_W-1:0] res_value;
  logic             do_append;
  logic             do_register;
  logic             do_consume;
  logic             out_free;

  assign sub_idx  = RD_W'(req_sub_q);
  assign sub_ok   = 32'(req_sub_q) < 32'(count_q);
  assign rp_sel   = rp_q[sub_idx];
  assign pending  = ptr_dist(rp_sel, write_q);
  assign held     = ptr_dist(oldest_q, write_q);
  assign amt_ok   = 32'(req_amount_q) <= 32'(pending);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < MAX_READERS; i++) begin
      if ((32'(i) < 32'(count_q)) && (rp_q[i] == oldest_q)) blocked = 1'b1;
    end
  end

  // Whole-request check; nothing changes unless the request is valid.
  always_comb begin
    res_status  = STATUS_OK;
    res_value   = '0;
    do_append   = 1'b0;
    do_register = 1'b0;
    do_consume  = 1'b0;
    case (req_kind_q)
      KIND_APPEND: begin
        if (held >= PTR_W'(QUEUE_DEPTH)) res_status = STATUS_FULL;
        else do_append = 1'b1;
      end
      KIND_REGISTER: begin
        if (count_q >= CNT_W'(MAX_READERS)) begin
          res_status = STATUS_NO_SLOT;
        end else begin
          do_register = 1'b1;
          res_value   = VALUE_W'(count_q);
        end
      end
      KIND_COUNT: begin
        if (!sub_ok) res_status = STATUS_UNKNOWN;
        else res_value = VALUE_W'(pending);
      end
      KIND_READ: begin
        if (!sub_ok) res_status = STATUS_UNKNOWN;
        else if (!amt_ok) res_status = STATUS_RANGE;
      end
      KIND_CONSUME: begin
        if (!sub_ok) res_status = STATUS_UNKNOWN;
        else if (!amt_ok) res_status = STATUS_RANGE;
        else do_consume = 1'b1;
      end
      KIND_RECLAIM: begin
        res_status = STATUS_OK;
      end
      default: begin
        res_status = STATUS_RANGE;
      end
    endcase
  end

  assign stat_o.is_reclaim   = (req_kind_q == KIND_RECLAIM);
  assign stat_o.read_go      = (req_kind_q == KIND_READ) && sub_ok && amt_ok &&
                               (req_amount_q != '0);
  assign stat_o.reclaim_done = (oldest_q == write_q) || blocked;
  assign stat_o.read_last    = (remain_q == AMT_W'(1));
  assign stat_o.out_free     = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_kind_q   <= kind_i;
      req_sub_q    <= subscriber_i;
      req_amount_q <= amount_i;
      req_word_q   <= WORD_BITS'(packet_word_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      write_q  <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      remain_q <= '0;
      for (int i = 0; i < MAX_READERS; i++) rp_q[i] <= '0;
    end else begin
      if (cmd_i.commit && do_append) write_q <= ptr_inc(write_q);
      if (cmd_i.commit && do_register) begin
        rp_q[RD_W'(count_q)] <= oldest_q;
        count_q              <= count_q + 1'b1;
      end
      // The amount fits the pointer width once it is known not to exceed pending.
      if (cmd_i.commit && do_consume) begin
        rp_q[sub_idx] <= ptr_add(rp_sel, PTR_W'(req_amount_q));
      end
      if (cmd_i.step_reclaim) oldest_q <= ptr_inc(oldest_q);
      if (cmd_i.start_read) begin
        rd_ptr_q <= rp_sel;
        remain_q <= req_amount_q;
      end
      if (cmd_i.issue_read) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (cmd_i.emit_packet) remain_q <= remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_append) mem[ptr_slot(write_q)] <= req_word_q;
    if (cmd_i.issue_read) mem_rdata_q <= mem[ptr_slot(rd_ptr_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.emit_packet) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= res_status;
      value_q   <= res_value;
      packet_q  <= '0;
      carries_q <= 1'b0;
      last_q    <= 1'b1;
    end else if (cmd_i.emit_packet) begin
      status_q  <= STATUS_OK;
      value_q   <= '0;
      packet_q  <= PKT_W'(mem_rdata_q);
      carries_q <= 1'b1;
      last_q    <= stat_o.read_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign value_o          = value_q;
  assign packet_out_o     = packet_q;
  assign carries_packet_o = carries_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_reader_packet_queue_core.sv
// ----------------------------------------------------------------------------
// multi_reader_packet_queue_core
// Broadcast packet queue with one write pointer and a read pointer for each
// registered subscriber.
// ----------------------------------------------------------------------------
// The block takes one request word at a time. A request is accepted while
// idle and checked in the next cycle; a request with a single result word
// (append, register, count query, consume, rejected requests) then has its
// word loaded into the output register when the output is free. A read of N
// packets does, for each packet, a store read and then a load of the output
// register. A reclaim frees one packet per step, comparing the oldest pointer
// against all registered subscriber pointers and the write pointer at each
// step. A stalled output holds the sequence at the point where a word is to
// be loaded; a new request is still accepted while a finished word waits.
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_packet_queue_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mrpq_pkg::KIND_W-1:0]   kind_i,
  input  logic [mrpq_pkg::SUB_W-1:0]    subscriber_i,
  input  logic [mrpq_pkg::AMT_W-1:0]    amount_i,
  input  logic [mrpq_pkg::PKT_W-1:0]    packet_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mrpq_pkg::STATUS_W-1:0] status_o,
  output logic [mrpq_pkg::VALUE_W-1:0]  value_o,
  output logic [mrpq_pkg::PKT_W-1:0]    packet_out_o,
  output logic                          carries_packet_o,
  output logic                          last_o
);
  import mrpq_pkg::*;

  mrpq_cmd_t  cmd;
  mrpq_stat_t stat;

  mrpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrpq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .subscriber_i     (subscriber_i),
    .amount_i         (amount_i),
    .packet_word_i    (packet_word_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .value_o          (value_o),
    .packet_out_o     (packet_out_o),
    .carries_packet_o (carries_packet_o),
    .last_o           (last_o)
  );

  // A request is worked on alone, so the input is busy right after a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted a second word while a request was in work");

  // Packet words are only produced by a successful read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && carries_packet_o |-> status_o == STATUS_OK && value_o == '0)
    else $error("packet word carries a status or value");

  // Every request other than a read ends with its single word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !carries_packet_o |-> last_o)
    else $error("non-packet word without last mark");

  // A rejected request reports no value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> value_o == '0 && !carries_packet_o)
    else $error("rejected request reports a value");

endmodule

`default_nettype wire
